>>> sv/i2cbb_pkg.sv
// ----------------------------------------------------------------------------
// i2cbb_pkg
// Shared types, codes and constants for the I2C bit-bang master sequencer.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

    typedef enum logic [2:0] {
        OP_IDLE     = 3'd0,
        OP_START    = 3'd1,
        OP_STOP     = 3'd2,
        OP_WRITE    = 3'd3,
        OP_READ     = 3'd4,
        OP_SEND_ACK = 3'd5,
        OP_READ_ACK = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        PH_DATA  = 2'd0,
        PH_RISE  = 2'd1,
        PH_FALL  = 2'd2
    } t_phase;

    localparam int ACTION_W = 3;
    localparam int BYTE_W   = 8;
    localparam int STEP_W   = 5;

    localparam logic [STEP_W-1:0] LEN_START    = 5'd4;
    localparam logic [STEP_W-1:0] LEN_STOP     = 5'd3;
    localparam logic [STEP_W-1:0] LEN_WRITE    = 5'd24;
    localparam logic [STEP_W-1:0] LEN_READ     = 5'd25;
    localparam logic [STEP_W-1:0] LEN_SEND_ACK = 5'd3;
    localparam logic [STEP_W-1:0] LEN_READ_ACK = 5'd4;

    typedef struct packed {
        t_op                op;
        logic [STEP_W-1:0]  step;
        t_phase             phase;
        logic [BYTE_W-1:0]  tx_shift;
        logic [BYTE_W-1:0]  rx_shift;
        logic               ack_drive;
        logic               ack_sampled;
        logic               scl_drive;
        logic               sda_drive;
    } t_state;

    typedef struct packed {
        logic               scl_level;
        logic               sda_level;
        logic               busy_res;
        logic               op_done;
        logic [BYTE_W-1:0]  rx_byte;
        logic               ack_seen;
        logic               rejected;
    } t_result;

    localparam t_state STATE_RESET = '{
        op:          OP_IDLE,
        step:        '0,
        phase:       PH_DATA,
        tx_shift:    '0,
        rx_shift:    '0,
        ack_drive:   1'b1,
        ack_sampled: 1'b1,
        scl_drive:   1'b1,
        sda_drive:   1'b1
    };

    function automatic logic [STEP_W-1:0] op_length(input t_op op);
        logic [STEP_W-1:0] len;
        case (op)
            OP_START:    len = LEN_START;
            OP_STOP:     len = LEN_STOP;
            OP_WRITE:    len = LEN_WRITE;
            OP_READ:     len = LEN_READ;
            OP_SEND_ACK: len = LEN_SEND_ACK;
            OP_READ_ACK: len = LEN_READ_ACK;
            default:     len = '0;
        endcase
        return len;
    endfunction

    function automatic t_phase phase_next(input t_phase ph);
        t_phase nx;
        case (ph)
            PH_DATA: nx = PH_RISE;
            PH_RISE: nx = PH_FALL;
            default: nx = PH_DATA;
        endcase
        return nx;
    endfunction

endpackage

>>> sv/i2cbb_step.sv
// ----------------------------------------------------------------------------
// i2cbb_step
// Next-state and result logic for one item: command latch or one bus step.
// ----------------------------------------------------------------------------
module i2cbb_step (
    input  i2cbb_pkg::t_state               i_state,
    input  logic [i2cbb_pkg::ACTION_W-1:0]  i_action,
    input  logic [i2cbb_pkg::BYTE_W-1:0]    i_tx_byte,
    input  logic                            i_ack_out,
    input  logic                            i_sda_in,
    output i2cbb_pkg::t_state               o_state,
    output i2cbb_pkg::t_result              o_result
);
    import i2cbb_pkg::*;

    t_state            n_state;
    logic              done;
    logic              rej;
    logic              is_cmd;
    logic [STEP_W-1:0] step_inc;

    assign is_cmd   = (i_action >= OP_START) && (i_action <= OP_READ_ACK);
    assign step_inc = i_state.step + STEP_W'(1);

    always_comb begin
        n_state = i_state;
        done    = 1'b0;
        rej     = 1'b0;
        if (is_cmd) begin
            if (i_state.op != OP_IDLE) begin
                rej = 1'b1;
            end else begin
                n_state.op    = t_op'(i_action);
                n_state.step  = '0;
                n_state.phase = PH_DATA;
                case (t_op'(i_action))
                    OP_WRITE:    n_state.tx_shift  = i_tx_byte;
                    OP_READ:     n_state.rx_shift  = '0;
                    OP_SEND_ACK: n_state.ack_drive = i_ack_out;
                    default: ;
                endcase
            end
        end else if (i_state.op != OP_IDLE) begin
            case (i_state.op)
                OP_START: begin
                    case (i_state.step)
                        5'd0:    n_state.sda_drive = 1'b1;
                        5'd1:    n_state.scl_drive = 1'b1;
                        5'd2:    n_state.sda_drive = 1'b0;
                        default: n_state.scl_drive = 1'b0;
                    endcase
                end
                OP_STOP: begin
                    case (i_state.step)
                        5'd0:    n_state.sda_drive = 1'b0;
                        5'd1:    n_state.scl_drive = 1'b1;
                        default: n_state.sda_drive = 1'b1;
                    endcase
                end
                OP_WRITE: begin
                    n_state.phase = phase_next(i_state.phase);
                    case (i_state.phase)
                        PH_DATA: n_state.sda_drive = i_state.tx_shift[BYTE_W-1];
                        PH_RISE: n_state.scl_drive = 1'b1;
                        default: begin
                            n_state.scl_drive = 1'b0;
                            n_state.tx_shift  = {i_state.tx_shift[BYTE_W-2:0], 1'b0};
                        end
                    endcase
                end
                OP_READ: begin
                    if (i_state.step == '0) begin
                        n_state.sda_drive = 1'b1;
                    end else begin
                        n_state.phase = phase_next(i_state.phase);
                        case (i_state.phase)
                            PH_DATA: n_state.scl_drive = 1'b1;
                            PH_RISE: n_state.rx_shift  =
                                {i_state.rx_shift[BYTE_W-2:0], i_sda_in};
                            default: n_state.scl_drive = 1'b0;
                        endcase
                    end
                end
                OP_SEND_ACK: begin
                    case (i_state.step)
                        5'd0:    n_state.sda_drive = i_state.ack_drive;
                        5'd1:    n_state.scl_drive = 1'b1;
                        default: n_state.scl_drive = 1'b0;
                    endcase
                end
                OP_READ_ACK: begin
                    case (i_state.step)
                        5'd0:    n_state.sda_drive   = 1'b1;
                        5'd1:    n_state.scl_drive   = 1'b1;
                        5'd2:    n_state.ack_sampled = i_sda_in;
                        default: n_state.scl_drive   = 1'b0;
                    endcase
                end
                default: ;
            endcase
            n_state.step = step_inc;
            if (step_inc >= op_length(i_state.op)) begin
                n_state.op    = OP_IDLE;
                n_state.step  = '0;
                n_state.phase = PH_DATA;
                done          = 1'b1;
            end
        end
    end

    assign o_state = n_state;

    always_comb begin
        o_result.scl_level = n_state.scl_drive;
        o_result.sda_level = n_state.sda_drive;
        o_result.busy_res  = (n_state.op != OP_IDLE);
        o_result.op_done   = done;
        o_result.rx_byte   = n_state.rx_shift;
        o_result.ack_seen  = n_state.ack_sampled;
        o_result.rejected  = rej;
    end

endmodule

>>> sv/i2c_bitbang_master_sequencer_core.sv
// ----------------------------------------------------------------------------
// Input accept reaches result valid via the input reg and the result reg.
// Throughput: one item per cycle unless stalled; input reg, step, result reg.
// Ready deasserts only while both the input and result registers are full
// and the result is not taken.
// Reset (synchronous, active low): idle, SCL and SDA released, queues empty.
// ----------------------------------------------------------------------------
// i2c_bitbang_master_sequencer_core
// Byte-level I2C master sequencer: start, stop, byte write/read, ack handling.
// ----------------------------------------------------------------------------
module i2c_bitbang_master_sequencer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [i2cbb_pkg::ACTION_W-1:0]  i_action,
    input  logic [i2cbb_pkg::BYTE_W-1:0]    i_tx_byte,
    input  logic                            i_ack_out,
    input  logic                            i_sda_in,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_scl_level,
    output logic                            o_sda_level,
    output logic                            o_busy_res,
    output logic                            o_op_done,
    output logic [i2cbb_pkg::BYTE_W-1:0]    o_rx_byte,
    output logic                            o_ack_seen,
    output logic                            o_rejected
);
    import i2cbb_pkg::*;

    logic                r_in_valid;
    logic [ACTION_W-1:0] r_action;
    logic [BYTE_W-1:0]   r_tx_byte;
    logic                r_ack_out;
    logic                r_sda_in;
    t_state              r_state;
    t_state              n_state;
    t_result             n_result;
    t_result             r_result;
    logic                r_out_valid;
    logic                advance;
    logic                in_take;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign in_take = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_action  <= i_action;
            r_tx_byte <= i_tx_byte;
            r_ack_out <= i_ack_out;
            r_sda_in  <= i_sda_in;
        end
    end

    i2cbb_step u_step (
        .i_state   (r_state),
        .i_action  (r_action),
        .i_tx_byte (r_tx_byte),
        .i_ack_out (r_ack_out),
        .i_sda_in  (r_sda_in),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            r_out_valid <= advance || (r_out_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_scl_level = r_result.scl_level;
    assign o_sda_level = r_result.sda_level;
    assign o_busy_res  = r_result.busy_res;
    assign o_op_done   = r_result.op_done;
    assign o_rx_byte   = r_result.rx_byte;
    assign o_ack_seen  = r_result.ack_seen;
    assign o_rejected  = r_result.rejected;

endmodule

>>> sv/i2cbb_checker.sv
// ----------------------------------------------------------------------------
// i2cbb_checker
// Port-level checks for the I2C bit-bang master sequencer, bound to the top.
// ----------------------------------------------------------------------------
module i2cbb_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic [i2cbb_pkg::ACTION_W-1:0]  i_action,
    input logic [i2cbb_pkg::BYTE_W-1:0]    i_tx_byte,
    input logic                            i_ack_out,
    input logic                            i_sda_in,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic                            o_scl_level,
    input logic                            o_sda_level,
    input logic                            o_busy_res,
    input logic                            o_op_done,
    input logic [i2cbb_pkg::BYTE_W-1:0]    o_rx_byte,
    input logic                            o_ack_seen,
    input logic                            o_rejected
);

    // no result straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a rejected command leaves the running operation busy
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rejected) |-> o_busy_res)
        else $error("reject reported while idle");

    // the last step ends the operation and is never a reject
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_op_done) |-> (!o_busy_res && !o_rejected))
        else $error("done with busy or reject");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_rx_byte)
            && $stable(o_scl_level) && $stable(o_sda_level) && $stable(o_busy_res)
            && $stable(o_ack_seen)))
        else $error("stalled result changed");

    // waiting input item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_ready) |=> (i_valid && $stable(i_action)
            && $stable(i_tx_byte) && $stable(i_ack_out) && $stable(i_sda_in)))
        else $error("waiting input item changed");

endmodule

bind i2c_bitbang_master_sequencer_core i2cbb_checker u_i2cbb_checker (.*);
